// File: rtl/sha256u_pkg.sv
// types, constants and round functions shared by the sha-256 hasher
package sha256u_pkg;

   typedef logic [31:0] word_type;
   typedef logic [7:0][31:0] vars_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MARK,
      ST_ZERO,
      ST_LEN,
      ST_INIT,
      ST_SCHED,
      ST_ROUND,
      ST_UPDATE,
      ST_OUT
   } state_type;

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [5:0] LEN_OFFSET = 6'd56;
   localparam logic [5:0] FILL_LAST  = 6'd63;
   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [2:0] WORD_LAST  = 3'd7;

   localparam logic [2:0] STEP_RD16 = 3'd0;
   localparam logic [2:0] STEP_RD15 = 3'd1;
   localparam logic [2:0] STEP_RD7  = 3'd2;
   localparam logic [2:0] STEP_RD2  = 3'd3;
   localparam logic [2:0] STEP_MIX  = 3'd4;

   localparam vars_type HASH_INIT = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic word_type big_sigma0(word_type v);
      return {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
   endfunction

   function automatic word_type big_sigma1(word_type v);
      return {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
   endfunction

   function automatic word_type small_sigma0(word_type v);
      return {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ {3'b000, v[31:3]};
   endfunction

   function automatic word_type small_sigma1(word_type v);
      return {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ {10'b0, v[31:10]};
   endfunction

endpackage

// File: rtl/sha256u_if.sv
// request and response channel interfaces of the sha-256 hasher
interface sha256u_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, data_byte, byte_present, end_of_message, input ready);
   modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256u_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: rtl/sha256u_round.sv
// one sha-256 compression round over the working variables
module sha256u_round (
   input  sha256u_pkg::vars_type vars,
   input  sha256u_pkg::word_type wt,
   input  sha256u_pkg::word_type k,
   output sha256u_pkg::vars_type vars_next
);

   sha256u_pkg::word_type ch;
   sha256u_pkg::word_type maj;
   sha256u_pkg::word_type t1;
   sha256u_pkg::word_type t2;

   always_comb begin
      ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
      maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
      t1  = vars[7] + sha256u_pkg::big_sigma1(vars[4]) + ch + k + wt;
      t2  = sha256u_pkg::big_sigma0(vars[0]) + maj;
      vars_next[7] = vars[6];
      vars_next[6] = vars[5];
      vars_next[5] = vars[4];
      vars_next[4] = vars[3] + t1;
      vars_next[3] = vars[2];
      vars_next[2] = vars[1];
      vars_next[1] = vars[0];
      vars_next[0] = t1 + t2;
   end

endmodule

// File: rtl/sha256_message_hasher_unit.sv
// sha-256 hasher: byte intake, padding, memory-based schedule and compression
// a full block holds off input during compression: rounds 0-15 read the block words directly
// and rounds 16-63 extend the schedule in separate read steps, all set by the single read port
// of the schedule memory; an end transaction adds the pad and length bytes, one or two
// compressions and the digest words; synchronous reset restores the initial hash,
// zero fill and zero length; no memory clear
module sha256_message_hasher_unit (
   input  logic                clock,
   input  logic                reset,
   sha256u_req_if.sink         req_chan,
   sha256u_rsp_if.source       rsp_chan
);

   sha256u_pkg::state_type state_ff, state_in;
   sha256u_pkg::state_type ret_ff, ret_in;

   logic [5:0]  fill_ff;
   logic [63:0] len_ff;
   logic [5:0]  round_ff;
   logic [2:0]  step_ff;
   logic [2:0]  idx_ff;
   sha256u_pkg::vars_type hash_ff;
   sha256u_pkg::vars_type vars_ff;
   sha256u_pkg::vars_type vars_next;
   logic [31:0] word_ff;
   logic [31:0] acc_ff;
   logic [31:0] rdata_ff;
   logic [31:0] msg_mem [16];

   logic        req_ready;
   logic        rsp_valid;
   logic        req_fire;
   logic        rsp_fire;
   logic        append_en;
   logic [7:0]  append_byte;
   logic        blk_full;
   logic        sched_ext;
   logic [63:0] len_shift;
   logic [3:0]  raddr;
   logic        mem_we;
   logic [3:0]  mem_waddr;
   logic [31:0] mem_wdata;
   logic [31:0] wt;

   assign req_fire  = req_chan.valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_chan.ready;
   assign blk_full  = fill_ff == sha256u_pkg::FILL_LAST;
   assign sched_ext = round_ff[5:4] != 2'b00;
   assign len_shift = len_ff << {fill_ff[2:0], 3'b000};
   assign wt        = sched_ext ? acc_ff : rdata_ff;

   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.digest_word = hash_ff[idx_ff];
   assign rsp_chan.word_index  = idx_ff;
   assign rsp_chan.last_word   = idx_ff == sha256u_pkg::WORD_LAST;

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         sha256u_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.byte_present && blk_full) begin
                  state_in = sha256u_pkg::ST_INIT;
                  ret_in   = req_chan.end_of_message ? sha256u_pkg::ST_MARK
                                                     : sha256u_pkg::ST_IDLE;
               end else if (req_chan.end_of_message) begin
                  state_in = sha256u_pkg::ST_MARK;
               end
            end
         end
         sha256u_pkg::ST_MARK: begin
            if (blk_full) begin
               state_in = sha256u_pkg::ST_INIT;
               ret_in   = sha256u_pkg::ST_ZERO;
            end else begin
               state_in = sha256u_pkg::ST_ZERO;
            end
         end
         sha256u_pkg::ST_ZERO: begin
            if (fill_ff == sha256u_pkg::LEN_OFFSET) begin
               state_in = sha256u_pkg::ST_LEN;
            end else if (blk_full) begin
               state_in = sha256u_pkg::ST_INIT;
               ret_in   = sha256u_pkg::ST_ZERO;
            end
         end
         sha256u_pkg::ST_LEN: begin
            if (blk_full) begin
               state_in = sha256u_pkg::ST_INIT;
               ret_in   = sha256u_pkg::ST_OUT;
            end
         end
         sha256u_pkg::ST_INIT: state_in = sha256u_pkg::ST_SCHED;
         sha256u_pkg::ST_SCHED: begin
            if (!sched_ext || step_ff == sha256u_pkg::STEP_MIX) begin
               state_in = sha256u_pkg::ST_ROUND;
            end
         end
         sha256u_pkg::ST_ROUND: begin
            state_in = (round_ff == sha256u_pkg::ROUND_LAST) ? sha256u_pkg::ST_UPDATE
                                                             : sha256u_pkg::ST_SCHED;
         end
         sha256u_pkg::ST_UPDATE: state_in = ret_ff;
         sha256u_pkg::ST_OUT: begin
            if (rsp_fire && idx_ff == sha256u_pkg::WORD_LAST) begin
               state_in = sha256u_pkg::ST_IDLE;
            end
         end
         default: state_in = sha256u_pkg::ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      append_en   = 1'b0;
      append_byte = req_chan.data_byte;
      unique case (state_ff)
         sha256u_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            append_en = req_fire && req_chan.byte_present;
         end
         sha256u_pkg::ST_MARK: begin
            append_en   = 1'b1;
            append_byte = sha256u_pkg::PAD_BYTE;
         end
         sha256u_pkg::ST_ZERO: begin
            append_en   = fill_ff != sha256u_pkg::LEN_OFFSET;
            append_byte = 8'h00;
         end
         sha256u_pkg::ST_LEN: begin
            append_en   = 1'b1;
            append_byte = len_shift[63:56];
         end
         sha256u_pkg::ST_OUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   // schedule memory addressing
   always_comb begin
      raddr = round_ff[3:0];
      if (state_ff == sha256u_pkg::ST_SCHED) begin
         priority case (step_ff)
            sha256u_pkg::STEP_RD15: raddr = round_ff[3:0] + 4'd1;
            sha256u_pkg::STEP_RD7:  raddr = round_ff[3:0] + 4'd9;
            sha256u_pkg::STEP_RD2:  raddr = round_ff[3:0] + 4'd14;
            default:                raddr = round_ff[3:0];
         endcase
      end
      mem_we    = 1'b0;
      mem_waddr = fill_ff[5:2];
      mem_wdata = {word_ff[23:0], append_byte};
      if (append_en && fill_ff[1:0] == 2'b11) begin
         mem_we = 1'b1;
      end else if (state_ff == sha256u_pkg::ST_SCHED && sched_ext &&
                   step_ff == sha256u_pkg::STEP_MIX) begin
         mem_we    = 1'b1;
         mem_waddr = round_ff[3:0];
         mem_wdata = acc_ff + sha256u_pkg::small_sigma1(rdata_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         msg_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= msg_mem[raddr];
   end

   sha256u_round u_round (
      .vars      (vars_ff),
      .wt        (wt),
      .k         (sha256u_pkg::ROUND_K[round_ff]),
      .vars_next (vars_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha256u_pkg::ST_IDLE;
         ret_ff   <= sha256u_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   // control state and hash words
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         len_ff   <= '0;
         round_ff <= '0;
         step_ff  <= '0;
         idx_ff   <= '0;
         hash_ff  <= sha256u_pkg::HASH_INIT;
      end else begin
         if (append_en) begin
            fill_ff <= fill_ff + 6'd1;
         end
         if (req_fire && req_chan.byte_present) begin
            len_ff <= len_ff + 64'd8;
         end
         unique case (state_ff)
            sha256u_pkg::ST_INIT: begin
               round_ff <= '0;
               step_ff  <= '0;
            end
            sha256u_pkg::ST_SCHED: begin
               if (!sched_ext || step_ff == sha256u_pkg::STEP_MIX) begin
                  step_ff <= '0;
               end else begin
                  step_ff <= step_ff + 3'd1;
               end
            end
            sha256u_pkg::ST_ROUND: round_ff <= round_ff + 6'd1;
            sha256u_pkg::ST_UPDATE: begin
               for (int i = 0; i < 8; i++) begin
                  hash_ff[i] <= hash_ff[i] + vars_ff[i];
               end
            end
            sha256u_pkg::ST_OUT: begin
               if (rsp_fire) begin
                  idx_ff <= idx_ff + 3'd1;
                  if (idx_ff == sha256u_pkg::WORD_LAST) begin
                     hash_ff <= sha256u_pkg::HASH_INIT;
                     fill_ff <= '0;
                     len_ff  <= '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // byte packing, schedule accumulator and working variables
   always_ff @(posedge clock) begin
      if (append_en) begin
         word_ff <= {word_ff[23:0], append_byte};
      end
      if (state_ff == sha256u_pkg::ST_INIT) begin
         vars_ff <= hash_ff;
      end else if (state_ff == sha256u_pkg::ST_ROUND) begin
         vars_ff <= vars_next;
      end
      if (state_ff == sha256u_pkg::ST_SCHED) begin
         priority case (step_ff)
            sha256u_pkg::STEP_RD15: acc_ff <= rdata_ff;
            sha256u_pkg::STEP_RD7:  acc_ff <= acc_ff + sha256u_pkg::small_sigma0(rdata_ff);
            sha256u_pkg::STEP_RD2:  acc_ff <= acc_ff + rdata_ff;
            sha256u_pkg::STEP_MIX:  acc_ff <= mem_wdata;
            default: ;
         endcase
      end
   end

   a_len_aligned: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha256u_pkg::ST_LEN |-> fill_ff[5:3] == 3'b111)
      else $error("length bytes outside the last eight block bytes");

   a_round_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha256u_pkg::ST_IDLE |-> round_ff == 6'd0 && step_ff == 3'd0)
      else $error("round counter not cleared between blocks");

   a_short_sched: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha256u_pkg::ST_SCHED && !sched_ext |-> step_ff == sha256u_pkg::STEP_RD16)
      else $error("schedule steps used for a round that reads the block directly");

   a_rearm: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && idx_ff == sha256u_pkg::WORD_LAST |=>
         len_ff == 64'd0 && fill_ff == 6'd0 && hash_ff == sha256u_pkg::HASH_INIT)
      else $error("hasher not re-armed after the last digest word");

   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha256u_pkg::ST_ROUND |-> !req_ready && !rsp_valid)
      else $error("channel open during compression");

endmodule
